>>> hw/rtl/urog_pkg.sv
// Package for the ultrasonic range and obstacle gate.
// Holds widths, the fixed-point reciprocals for the divisions, codes and stage words.
// Has no dependencies; every RTL file of the block refers to it by scoped names.
package urog_pkg;

  // Field widths.
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned SPEED_W  = 9;
  localparam int unsigned DIST_W   = 11;
  localparam int unsigned CFG_W    = 11;

  // Distance window.
  localparam int unsigned WINDOW_LEN = 6;
  localparam int unsigned IDX_W      = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W      = DIST_W + $clog2(WINDOW_LEN);

  // Echo conversion: mm = periods * speed / 80 = ((periods * speed) >> 4) / 5.
  // The divide by five is a multiply by ceil(2^18 / 5); it is exact for inputs below 2^18.
  localparam int unsigned PROD_W       = PERIOD_W + SPEED_W;
  localparam int unsigned MM_PRE_SHIFT = 4;
  localparam int unsigned MM_Y_W       = PROD_W - MM_PRE_SHIFT;
  localparam int unsigned MM_RECIP_W   = 16;
  localparam int unsigned MM_RECIP     = 52429;
  localparam int unsigned MM_SHIFT     = 18;
  localparam int unsigned MM_MUL_W     = MM_Y_W + MM_RECIP_W;

  // Window mean: sum / WINDOW_LEN as a multiply by ceil(2^AVG_SHIFT / WINDOW_LEN).
  // The shift leaves enough guard bits that the truncated quotient is exact for any sum.
  localparam int unsigned AVG_SHIFT = SUM_W + IDX_W + 1;
  localparam int unsigned AVG_RECIP = ((1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int unsigned AVG_MUL_W = SUM_W + AVG_SHIFT;

  // Reset values of the configuration registers.
  localparam logic [SPEED_W-1:0] SOUND_SPEED_RST = SPEED_W'(315);
  localparam logic [DIST_W-1:0]  OBSTACLE_THR_RST = DIST_W'(500);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SOUND_SPEED  = 1'b0,
    CFG_OBSTACLE_THR = 1'b1
  } cfg_idx_e;

  // Drive commands.
  typedef enum logic [1:0] {
    CMD_HALT    = 2'd0,
    CMD_FORWARD = 2'd1,
    CMD_AVOID   = 2'd2
  } drive_cmd_e;

  // Button and echo flags of one word.
  typedef struct packed {
    logic start;
    logic stop;
    logic echo;
  } flags_t;

  // Word leaving the conversion pipeline.
  typedef struct packed {
    flags_t             flags;
    logic [DIST_W-1:0]  dist_mm;
  } conv_t;

  // Word leaving the tracking stage.
  typedef struct packed {
    drive_cmd_e         cmd;
    logic [DIST_W-1:0]  dist_mm;
    logic               running;
    logic [SUM_W-1:0]   sum;
  } track_t;

endpackage

>>> hw/rtl/urog_convert.sv
// Echo conversion pipeline: input register, product register, distance register.
// Turns an echo time in 25 us periods into millimetres. Depends on urog_pkg.
module urog_convert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [urog_pkg::SPEED_W-1:0]  sound_speed_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  urog_pkg::flags_t              in_flags_i,
  input  logic [urog_pkg::PERIOD_W-1:0] in_periods_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output urog_pkg::conv_t               out_word_o
);

  logic                              v1_q, v2_q, v3_q;
  logic                              adv1, adv2, adv3;
  urog_pkg::flags_t                  flags1_q, flags2_q;
  logic [urog_pkg::PERIOD_W-1:0]     periods_q;
  logic [urog_pkg::PROD_W-1:0]       prod_d, prod_q;
  logic [urog_pkg::MM_Y_W-1:0]       y;
  logic [urog_pkg::MM_MUL_W-1:0]     quot_full;
  urog_pkg::conv_t                   word_d, word_q;

  // A stage moves when it is empty or the next one moves.
  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  // Periods times speed of sound.
  assign prod_d = urog_pkg::PROD_W'(periods_q) * urog_pkg::PROD_W'(sound_speed_i);

  // Divide by 80: drop four bits, then divide by five through the reciprocal.
  assign y         = prod_q[urog_pkg::PROD_W-1:urog_pkg::MM_PRE_SHIFT];
  assign quot_full = urog_pkg::MM_MUL_W'(y) *
                     urog_pkg::MM_MUL_W'(urog_pkg::MM_RECIP);

  always_comb begin
    word_d.flags   = flags2_q;
    word_d.dist_mm = quot_full[urog_pkg::MM_SHIFT +: urog_pkg::DIST_W];
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      flags1_q  <= in_flags_i;
      periods_q <= in_periods_i;
    end
    if (adv2) begin
      flags2_q <= flags1_q;
      prod_q   <= prod_d;
    end
    if (adv3) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_word_o  = word_q;

endmodule

>>> hw/rtl/urog_track.sv
// Tracking stage: run flag, distance window, running sum and drive decision.
// All tracking state lives here and is updated once per word. Depends on urog_pkg.
module urog_track (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [urog_pkg::DIST_W-1:0]  threshold_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  urog_pkg::conv_t              in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output urog_pkg::track_t             out_word_o
);

  logic                              v_q;
  logic                              adv;
  logic                              take;
  logic                              run_d, run_q;
  logic [urog_pkg::DIST_W-1:0]       last_d, last_q;
  logic [urog_pkg::SUM_W-1:0]        sum_d, sum_q;
  logic [urog_pkg::IDX_W-1:0]        idx_d, idx_q;
  logic [urog_pkg::DIST_W-1:0]       win_q [urog_pkg::WINDOW_LEN];
  urog_pkg::drive_cmd_e              cmd;
  urog_pkg::track_t                  word_d, word_q;

  assign adv        = !v_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign take       = in_valid_i && adv;

  // Next state: stop first, then start, so start wins.
  always_comb begin
    run_d  = run_q;
    last_d = last_q;
    sum_d  = sum_q;
    idx_d  = idx_q;
    if (in_word_i.flags.stop) begin
      run_d = 1'b0;
    end
    if (in_word_i.flags.start) begin
      run_d = 1'b1;
    end
    if (in_word_i.flags.echo) begin
      sum_d  = sum_q - urog_pkg::SUM_W'(win_q[idx_q]) +
               urog_pkg::SUM_W'(in_word_i.dist_mm);
      last_d = in_word_i.dist_mm;
      if (idx_q == urog_pkg::IDX_W'(urog_pkg::WINDOW_LEN - 1)) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + urog_pkg::IDX_W'(1);
      end
    end
  end

  // Drive decision; a distance equal to the threshold counts as free.
  always_comb begin
    if (!run_d) begin
      cmd = urog_pkg::CMD_HALT;
    end else if (last_d < threshold_i) begin
      cmd = urog_pkg::CMD_AVOID;
    end else begin
      cmd = urog_pkg::CMD_FORWARD;
    end
  end

  always_comb begin
    word_d.cmd     = cmd;
    word_d.dist_mm = last_d;
    word_d.running = run_d;
    word_d.sum     = sum_d;
  end

  // State and valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      run_q  <= 1'b0;
      last_q <= '0;
      sum_q  <= '0;
      idx_q  <= '0;
      for (int i = 0; i < urog_pkg::WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (adv) begin
        v_q <= in_valid_i;
      end
      if (take) begin
        run_q  <= run_d;
        last_q <= last_d;
        sum_q  <= sum_d;
        idx_q  <= idx_d;
        if (in_word_i.flags.echo) begin
          win_q[idx_q] <= in_word_i.dist_mm;
        end
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_word_o  = word_q;

endmodule

>>> hw/rtl/urog_average.sv
// Output stage: divides the window sum by the window length and holds the result word.
// Depends on urog_pkg.
module urog_average (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  urog_pkg::track_t             in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output urog_pkg::drive_cmd_e         cmd_o,
  output logic [urog_pkg::DIST_W-1:0]  dist_o,
  output logic [urog_pkg::DIST_W-1:0]  avg_o,
  output logic                         running_o
);

  logic                              v_q;
  logic                              adv;
  logic [urog_pkg::AVG_MUL_W-1:0]    avg_full;
  urog_pkg::drive_cmd_e              cmd_q;
  logic [urog_pkg::DIST_W-1:0]       dist_q, avg_q;
  logic                              running_q;

  assign adv        = !v_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Mean through the reciprocal of the window length.
  assign avg_full = urog_pkg::AVG_MUL_W'(in_word_i.sum) *
                    urog_pkg::AVG_MUL_W'(urog_pkg::AVG_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      cmd_q     <= in_word_i.cmd;
      dist_q    <= in_word_i.dist_mm;
      avg_q     <= avg_full[urog_pkg::AVG_SHIFT +: urog_pkg::DIST_W];
      running_q <= in_word_i.running;
    end
  end

  assign out_valid_o = v_q;
  assign cmd_o       = cmd_q;
  assign dist_o      = dist_q;
  assign avg_o       = avg_q;
  assign running_o   = running_q;

endmodule

>>> hw/rtl/ultrasonic_range_obstacle_gate.sv
// Top level of the ultrasonic range and obstacle gate.
// Instantiates urog_convert, urog_track and urog_average; depends on urog_pkg.
//
//   Channel | Direction | Handshake            | Word
//   --------+-----------+----------------------+--------------------------------------------
//   in      | input     | in_valid_i/in_stall_o | start, stop, echo flags, echo periods
//   out     | output    | out_valid_o/out_stall_i | drive command, distance, average, running
//   cfg     | input     | cfg_we_i              | register index and data, write only
//
// One word is accepted every cycle while in_stall_o is low; it passes five registers
// (input, product, distance, tracking and output) on its way to the out channel.
// Reset clears the run flag, the distance window, its sum and index, and sets the
// configuration registers to 315 m/s and 500 mm.
// Each stage holds its word while the next one cannot move; a stall on the output backs up
// only as far as the first empty stage, so bubbles are squeezed out.
module ultrasonic_range_obstacle_gate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [urog_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_pressed_i,
  input  logic                          stop_pressed_i,
  input  logic                          echo_valid_i,
  input  logic [urog_pkg::PERIOD_W-1:0] echo_periods_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    drive_command_o,
  output logic [urog_pkg::DIST_W-1:0]   distance_mm_o,
  output logic [urog_pkg::DIST_W-1:0]   average_mm_o,
  output logic                          running_o
);

  logic [urog_pkg::SPEED_W-1:0] sound_speed_q;
  logic [urog_pkg::DIST_W-1:0]  threshold_q;
  urog_pkg::flags_t             in_flags;
  urog_pkg::conv_t              conv_word;
  logic                         conv_valid, conv_stall;
  urog_pkg::track_t             track_word;
  logic                         track_valid, track_stall;
  urog_pkg::drive_cmd_e         cmd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sound_speed_q <= urog_pkg::SOUND_SPEED_RST;
      threshold_q   <= urog_pkg::OBSTACLE_THR_RST;
    end else if (cfg_we_i) begin
      unique case (urog_pkg::cfg_idx_e'(cfg_idx_i))
        urog_pkg::CFG_SOUND_SPEED: begin
          sound_speed_q <= cfg_data_i[urog_pkg::SPEED_W-1:0];
        end
        urog_pkg::CFG_OBSTACLE_THR: begin
          threshold_q <= cfg_data_i[urog_pkg::DIST_W-1:0];
        end
        default: begin
          threshold_q <= threshold_q;
        end
      endcase
    end
  end

  always_comb begin
    in_flags.start = start_pressed_i;
    in_flags.stop  = stop_pressed_i;
    in_flags.echo  = echo_valid_i;
  end

  urog_convert u_convert (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sound_speed_i (sound_speed_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_flags_i    (in_flags),
    .in_periods_i  (echo_periods_i),
    .out_valid_o   (conv_valid),
    .out_stall_i   (conv_stall),
    .out_word_o    (conv_word)
  );

  urog_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (threshold_q),
    .in_valid_i  (conv_valid),
    .in_stall_o  (conv_stall),
    .in_word_i   (conv_word),
    .out_valid_o (track_valid),
    .out_stall_i (track_stall),
    .out_word_o  (track_word)
  );

  urog_average u_average (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (track_valid),
    .in_stall_o  (track_stall),
    .in_word_i   (track_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .dist_o      (distance_mm_o),
    .avg_o       (average_mm_o),
    .running_o   (running_o)
  );

  assign drive_command_o = cmd;

endmodule
